>>> hdl/acdb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acdb_pkg
// Shared types, constants and time arithmetic for the alarm clock block.
// ----------------------------------------------------------------------------
package acdb_pkg;

	localparam int NUM_KEYS             = 4;
	localparam int DEBOUNCE_SAMPLES_DEF = 4;
	localparam int SEG_W                = 8;
	localparam int TPS_W                = 8;
	localparam int HOLD_W               = 16;
	localparam int CFG_INDEX_W          = 1;
	localparam int CFG_DATA_W           = 16;

	localparam logic [TPS_W-1:0]  TPS_RESET  = 8'd20;
	localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd2500;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TICKS_PER_SECOND = 1'b0,
		REG_ALARM_HOLD_TICKS = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_RUN       = 2'd0,
		MODE_SET_TIME  = 2'd1,
		MODE_SET_ALARM = 2'd2
	} mode_t;

	// time of day held as BCD digits, always in 00:00:00 .. 23:59:59
	typedef struct packed {
		logic [1:0] h_t;
		logic [3:0] h_u;
		logic [2:0] m_t;
		logic [3:0] m_u;
		logic [2:0] s_t;
		logic [3:0] s_u;
	} time_t;

	localparam time_t TIME_ZERO = '0;
	localparam time_t TIME_NOON = '{h_t: 2'd1, h_u: 4'd2, m_t: 3'd0, m_u: 4'd0,
		s_t: 3'd0, s_u: 4'd0};

	// past 23:xx the sum reaches a full day and the time drops to midnight
	function automatic time_t add_hour(time_t t);
		time_t r;
		r = t;
		if (t.h_t == 2'd2 && t.h_u == 4'd3) begin
			r = TIME_ZERO;
		end else if (t.h_u == 4'd9) begin
			r.h_u = 4'd0;
			r.h_t = 2'(t.h_t + 2'd1);
		end else begin
			r.h_u = 4'(t.h_u + 4'd1);
		end
		return r;
	endfunction

	function automatic time_t add_minute(time_t t);
		time_t r;
		r = t;
		if (t.m_t == 3'd5 && t.m_u == 4'd9) begin
			r.m_t = 3'd0;
			r.m_u = 4'd0;
			r = add_hour(r);
		end else if (t.m_u == 4'd9) begin
			r.m_u = 4'd0;
			r.m_t = 3'(t.m_t + 3'd1);
		end else begin
			r.m_u = 4'(t.m_u + 4'd1);
		end
		return r;
	endfunction

	function automatic time_t add_second(time_t t);
		time_t r;
		r = t;
		if (t.s_t == 3'd5 && t.s_u == 4'd9) begin
			r.s_t = 3'd0;
			r.s_u = 4'd0;
			r = add_minute(r);
		end else if (t.s_u == 4'd9) begin
			r.s_u = 4'd0;
			r.s_t = 3'(t.s_t + 3'd1);
		end else begin
			r.s_u = 4'(t.s_u + 4'd1);
		end
		return r;
	endfunction

	// common cathode, segment a in bit 0
	function automatic logic [SEG_W-1:0] seg_code(logic [3:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0:    s = 8'h3f;
			4'd1:    s = 8'h06;
			4'd2:    s = 8'h5b;
			4'd3:    s = 8'h4f;
			4'd4:    s = 8'h66;
			4'd5:    s = 8'h6d;
			4'd6:    s = 8'h7d;
			4'd7:    s = 8'h07;
			4'd8:    s = 8'h7f;
			4'd9:    s = 8'h6f;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

>>> hdl/acdb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acdb_if
// Handshake channels of the alarm clock: tick items, results, config writes.
// ----------------------------------------------------------------------------
interface acdb_item_if;
	logic                          valid;
	logic                          ready;
	logic                          base_tick;
	logic                          scan_tick;
	logic [acdb_pkg::NUM_KEYS-1:0] keys_raw;

	modport source (output valid, base_tick, scan_tick, keys_raw, input ready);
	modport sink   (input valid, base_tick, scan_tick, keys_raw, output ready);
endinterface

interface acdb_result_if;
	logic                       valid;
	logic                       ready;
	logic [acdb_pkg::SEG_W-1:0] hour_tens_seg;
	logic [acdb_pkg::SEG_W-1:0] hour_units_seg;
	logic [acdb_pkg::SEG_W-1:0] minute_tens_seg;
	logic [acdb_pkg::SEG_W-1:0] minute_units_seg;
	logic [acdb_pkg::SEG_W-1:0] second_tens_seg;
	logic [acdb_pkg::SEG_W-1:0] second_units_seg;
	logic                       alarm_active;
	logic                       showing_alarm;
	logic [1:0]                 clock_mode;

	modport source (output valid, hour_tens_seg, hour_units_seg, minute_tens_seg,
		minute_units_seg, second_tens_seg, second_units_seg, alarm_active,
		showing_alarm, clock_mode, input ready);
	modport sink   (input valid, hour_tens_seg, hour_units_seg, minute_tens_seg,
		minute_units_seg, second_tens_seg, second_units_seg, alarm_active,
		showing_alarm, clock_mode, output ready);
endinterface

interface acdb_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [acdb_pkg::CFG_INDEX_W-1:0]  index;
	logic [acdb_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/alarm_clock_with_key_debounce_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_clock_with_key_debounce_unit
// 24-hour alarm clock with debounced set keys and seven-segment digit codes.
// ----------------------------------------------------------------------------
// Result: the outputs for an accepted tick beat are registered and held until taken.
// Throughput: one beat per cycle while results are taken; the result register frees as it is taken.
// All clock and key state is updated in the accept cycle by one pass of logic.
// Reset: time 00:00:00, alarm 12:00:00, run mode, keys released,
// ticks_per_second 20, alarm_hold_ticks 2500.
module alarm_clock_with_key_debounce_unit #(
	parameter int DEBOUNCE_SAMPLES = acdb_pkg::DEBOUNCE_SAMPLES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	acdb_item_if.sink     item,
	acdb_result_if.source result,
	acdb_cfg_if.sink      cfg
);

	localparam int NK = acdb_pkg::NUM_KEYS;

	logic [acdb_pkg::TPS_W-1:0]  tps_q;
	logic [acdb_pkg::HOLD_W-1:0] hold_ticks_q;

	acdb_pkg::time_t              tod_q, tod_d;
	acdb_pkg::time_t              alarm_q, alarm_d;
	logic [acdb_pkg::TPS_W-1:0]   sub_q, sub_d;
	logic [acdb_pkg::HOLD_W-1:0]  hold_q, hold_d;
	logic                         alarm_on_q, alarm_on_d;
	logic [DEBOUNCE_SAMPLES-1:0]  samples_q [NK];
	logic [DEBOUNCE_SAMPLES-1:0]  samples_d [NK];
	logic [NK-1:0]                stable_q, stable_d;
	logic [NK-1:0]                prev_q;
	acdb_pkg::mode_t              mode_q, mode_d;

	acdb_pkg::time_t              shown;
	logic [2:0]                   pressed;
	logic                         setting;
	logic                         accept;
	logic                         res_valid_q;

	assign cfg.ready  = 1'b1;
	assign item.ready = !res_valid_q || result.ready;
	assign accept     = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q        <= acdb_pkg::TPS_RESET;
			hold_ticks_q <= acdb_pkg::HOLD_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				acdb_pkg::REG_TICKS_PER_SECOND: tps_q <= cfg.data[acdb_pkg::TPS_W-1:0];
				acdb_pkg::REG_ALARM_HOLD_TICKS: hold_ticks_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		tod_d      = tod_q;
		alarm_d    = alarm_q;
		sub_d      = sub_q;
		hold_d     = hold_q;
		alarm_on_d = alarm_on_q;
		stable_d   = stable_q;
		mode_d     = mode_q;
		pressed    = '0;
		for (int i = 0; i < NK; i++) begin
			samples_d[i] = samples_q[i];
		end

		if (item.base_tick && mode_q != acdb_pkg::MODE_SET_TIME) begin
			sub_d = sub_q + 1'b1;
			if (sub_d == tps_q) begin
				sub_d = '0;
				tod_d = acdb_pkg::add_second(tod_q);
			end
		end

		if (item.scan_tick) begin
			if (alarm_on_q) begin
				hold_d = hold_q + 1'b1;
				if (hold_d == hold_ticks_q) begin
					alarm_on_d = 1'b0;
					hold_d     = '0;
				end
			end
			for (int i = 0; i < NK; i++) begin
				samples_d[i] = {samples_q[i][DEBOUNCE_SAMPLES-2:0], item.keys_raw[i]};
				if (samples_d[i] == '0) begin
					stable_d[i] = 1'b0;
				end else if (samples_d[i] == '1) begin
					stable_d[i] = 1'b1;
				end
			end
		end

		// falling stable level is a press; highest key wins
		for (int i = 0; i < NK; i++) begin
			if (prev_q[i] && !stable_d[i]) begin
				pressed = 3'(i + 1);
			end
		end

		setting = (mode_q == acdb_pkg::MODE_SET_TIME) || (mode_q == acdb_pkg::MODE_SET_ALARM);
		case (pressed)
			3'd1: begin
				if (mode_q == acdb_pkg::MODE_SET_TIME) begin
					mode_d = acdb_pkg::MODE_RUN;
				end else if (mode_q != acdb_pkg::MODE_SET_ALARM) begin
					mode_d = acdb_pkg::MODE_SET_TIME;
				end
			end
			3'd2: begin
				if (mode_q == acdb_pkg::MODE_SET_ALARM) begin
					alarm_d = acdb_pkg::add_minute(alarm_q);
				end else if (setting) begin
					tod_d = acdb_pkg::add_minute(tod_d);
				end
			end
			3'd3: begin
				if (mode_q == acdb_pkg::MODE_SET_ALARM) begin
					alarm_d = acdb_pkg::add_hour(alarm_q);
				end else if (setting) begin
					tod_d = acdb_pkg::add_hour(tod_d);
				end
			end
			3'd4: begin
				if (mode_q == acdb_pkg::MODE_SET_ALARM) begin
					mode_d = acdb_pkg::MODE_RUN;
				end else if (mode_q != acdb_pkg::MODE_SET_TIME) begin
					mode_d = acdb_pkg::MODE_SET_ALARM;
				end
			end
			default: ;
		endcase

		if (tod_d == alarm_d) begin
			alarm_on_d = 1'b1;
		end

		shown = (mode_d == acdb_pkg::MODE_SET_ALARM) ? alarm_d : tod_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tod_q      <= acdb_pkg::TIME_ZERO;
			alarm_q    <= acdb_pkg::TIME_NOON;
			sub_q      <= '0;
			hold_q     <= '0;
			alarm_on_q <= 1'b0;
			stable_q   <= '1;
			prev_q     <= '1;
			mode_q     <= acdb_pkg::MODE_RUN;
			for (int i = 0; i < NK; i++) begin
				samples_q[i] <= '1;
			end
		end else if (accept) begin
			tod_q      <= tod_d;
			alarm_q    <= alarm_d;
			sub_q      <= sub_d;
			hold_q     <= hold_d;
			alarm_on_q <= alarm_on_d;
			stable_q   <= stable_d;
			prev_q     <= stable_d;
			mode_q     <= mode_d;
			for (int i = 0; i < NK; i++) begin
				samples_q[i] <= samples_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result.hour_tens_seg    <= acdb_pkg::seg_code(4'(shown.h_t));
			result.hour_units_seg   <= acdb_pkg::seg_code(shown.h_u);
			result.minute_tens_seg  <= acdb_pkg::seg_code(4'(shown.m_t));
			result.minute_units_seg <= acdb_pkg::seg_code(shown.m_u);
			result.second_tens_seg  <= acdb_pkg::seg_code(4'(shown.s_t));
			result.second_units_seg <= acdb_pkg::seg_code(shown.s_u);
			result.alarm_active     <= alarm_on_d;
			result.showing_alarm    <= (mode_d == acdb_pkg::MODE_SET_ALARM);
			result.clock_mode       <= mode_d;
		end
	end

	assign result.valid = res_valid_q;

endmodule

>>> hdl/acdb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acdb_checker
// Port-level checks on the alarm clock, bound to the top level.
// ----------------------------------------------------------------------------
module acdb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [47:0] res_segs,
	input logic        res_showing_alarm,
	input logic [1:0]  res_clock_mode
);

	logic item_beat;
	logic res_beat;

	assign item_beat = item_valid && item_ready;
	assign res_beat  = res_valid && res_ready;

	// each accepted tick yields a result in the next cycle
	ap_beat_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_beat |=> res_valid)
		else $error("accepted beat produced no result");

	// a result that is taken and not replaced goes away
	ap_no_extra_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_beat && !item_beat |=> !res_valid)
		else $error("result repeated without an accepted beat");

	// digits show the alarm exactly in set-alarm mode
	ap_showing_mode: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_showing_alarm == (res_clock_mode == acdb_pkg::MODE_SET_ALARM)))
		else $error("showing_alarm disagrees with clock_mode");

	ap_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_segs)
			&& $stable(res_clock_mode))
		else $error("stalled result changed");

endmodule

bind alarm_clock_with_key_debounce_unit acdb_checker u_acdb_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.item_valid        (item.valid),
	.item_ready        (item.ready),
	.res_valid         (result.valid),
	.res_ready         (result.ready),
	.res_segs          ({result.hour_tens_seg, result.hour_units_seg,
		result.minute_tens_seg, result.minute_units_seg,
		result.second_tens_seg, result.second_units_seg}),
	.res_showing_alarm (result.showing_alarm),
	.res_clock_mode    (result.clock_mode)
);
